// ===== src/mrbm_pkg.sv =====
// shared types, constants and helpers for the bank mapper
package mrbm_pkg;

  localparam int unsigned WINDOWS   = 8;
  localparam int unsigned WIN_W     = $clog2(WINDOWS);
  localparam int unsigned MAX_PAGES = 256;
  localparam int unsigned BANK_W    = 9;
  localparam int unsigned OFS_W     = 13;
  localparam int unsigned ROM_W     = 21;

  localparam logic [BANK_W-1:0] BANK_NONE    = 9'h1ff;
  localparam logic [4:0]        PLAIN_MASK   = 5'h1f;
  localparam logic [OFS_W-1:0]  SCC_OFS      = 13'h1000;
  localparam logic [BANK_W-1:0] PAGES_RESET  = 9'd8;

  localparam logic [WIN_W-1:0] WIN_FIRST = 3'd2;
  localparam logic [WIN_W-1:0] WIN_REG   = 3'd3;
  localparam logic [WIN_W-1:0] WIN_LAST  = 3'd5;
  localparam logic [WIN_W-1:0] WIN_HIGH  = 3'd4;

  localparam logic [1:0] CFG_MODE  = 2'd0;
  localparam logic [1:0] CFG_PAGES = 2'd1;
  localparam logic [1:0] CFG_FRONT = 2'd2;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_SCC   = 2'd1,
    MODE_8K    = 2'd2,
    MODE_16K   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [7:0]  data;
  } req_t;

  typedef struct packed {
    logic             rom_hit;
    logic [ROM_W-1:0] rom_offset;
    logic             register_written;
  } rsp_t;

  typedef struct packed {
    op_e               op;
    logic [WIN_W-1:0]  win;
    logic [OFS_W-1:0]  ofs;
    logic              wr_en;
    logic [WIN_W-1:0]  wr_win;
    logic              pair;
    logic              do_mod;
    logic [BANK_W-1:0] val;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } qrd_t;

  function automatic logic [BANK_W-1:0] pages_eff(input logic [BANK_W-1:0] pc);
    logic [BANK_W-1:0] lim;
    lim = BANK_W'(MAX_PAGES);
    return (pc > lim) ? lim : pc;
  endfunction

endpackage

// ===== src/mrbm_front.sv =====
// front end: request handshake and decode into bank commands
module mrbm_front (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  mrbm_pkg::req_t        in_req_i,
  input  mrbm_pkg::mode_e       mode_i,
  input  logic [8:0]            pages_i,
  input  logic                  q_full_i,
  output logic                  q_push_o,
  output mrbm_pkg::cmd_t        cmd_o
);

  logic [mrbm_pkg::WIN_W-1:0]  win;
  logic [mrbm_pkg::OFS_W-1:0]  ofs;
  logic [mrbm_pkg::BANK_W-1:0] neff;
  logic [mrbm_pkg::BANK_W-1:0] plain_b;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign win     = in_req_i.address[15:13];
  assign ofs     = in_req_i.address[12:0];
  assign neff    = mrbm_pkg::pages_eff(pages_i);
  assign plain_b = {4'b0, in_req_i.data[4:0] & mrbm_pkg::PLAIN_MASK};

  always_comb begin
    cmd_o        = '0;
    cmd_o.win    = win;
    cmd_o.ofs    = ofs;
    cmd_o.wr_win = win;
    cmd_o.val    = {1'b0, in_req_i.data};
    case (in_req_i.opcode)
      mrbm_pkg::OP_READ:  cmd_o.op = mrbm_pkg::OP_READ;
      mrbm_pkg::OP_WRITE: cmd_o.op = mrbm_pkg::OP_WRITE;
      mrbm_pkg::OP_LOAD:  cmd_o.op = mrbm_pkg::OP_LOAD;
      default:            cmd_o.op = mrbm_pkg::OP_NONE;
    endcase
    case (mode_i)
      mrbm_pkg::MODE_PLAIN: begin
        cmd_o.wr_en = (win >= mrbm_pkg::WIN_REG) && (win <= mrbm_pkg::WIN_LAST) && (ofs == '0);
        cmd_o.val   = (plain_b >= neff) ? mrbm_pkg::BANK_NONE : plain_b;
      end
      mrbm_pkg::MODE_SCC: begin
        cmd_o.wr_en  = (win >= mrbm_pkg::WIN_FIRST) && (win <= mrbm_pkg::WIN_LAST)
                       && (ofs == mrbm_pkg::SCC_OFS);
        cmd_o.do_mod = 1'b1;
      end
      mrbm_pkg::MODE_8K: begin
        cmd_o.wr_en  = (win == mrbm_pkg::WIN_REG);
        cmd_o.wr_win = {1'b0, ofs[12:11]} + mrbm_pkg::WIN_FIRST;
        cmd_o.do_mod = 1'b1;
      end
      default: begin
        cmd_o.wr_en  = (win == mrbm_pkg::WIN_REG) && !ofs[11];
        cmd_o.wr_win = ofs[12] ? mrbm_pkg::WIN_HIGH : mrbm_pkg::WIN_FIRST;
        cmd_o.pair   = 1'b1;
        cmd_o.val    = {in_req_i.data, 1'b0};
        cmd_o.do_mod = 1'b1;
      end
    endcase
  end

endmodule

// ===== src/mrbm_queue.sv =====
// short command queue between front and back
module mrbm_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mrbm_pkg::cmd_t cmd_i,
  output logic           full_o,
  output mrbm_pkg::qrd_t rd_o,
  input  logic           pop_i,
  output mrbm_pkg::cmd_t cmd_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  mrbm_pkg::cmd_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_pop;

  assign full_o      = (cnt_q == CntW'(DEPTH));
  assign rd_o.valid  = (cnt_q != '0);
  assign rd_o.pop    = do_pop;
  assign do_pop      = pop_i && (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ===== src/mrbm_back.sv =====
// back end: page reduction, bank registers and response register
module mrbm_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mrbm_pkg::qrd_t       rd_i,
  output logic                 pop_o,
  input  mrbm_pkg::cmd_t       cmd_i,
  input  logic [8:0]           pages_i,
  input  logic                 front_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mrbm_pkg::rsp_t       out_rsp_o,
  output logic                 busy_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_EXEC = 3'b100
  } state_e;

  localparam int unsigned BW = mrbm_pkg::BANK_W;
  localparam int unsigned WW = mrbm_pkg::WIN_W;

  state_e                state_q, state_d;
  mrbm_pkg::cmd_t        cmd_q, cmd_d;
  logic [BW-1:0]         rem_q, rem_d;
  logic [1:0]            cnt_q, cnt_d;
  logic [BW-1:0]         bank_q [mrbm_pkg::WINDOWS];
  logic [BW-1:0]         bank_d [mrbm_pkg::WINDOWS];
  logic                  out_valid_q, out_valid_d;
  mrbm_pkg::rsp_t        rsp_q, rsp_d;
  logic [BW-1:0]         neff;
  logic [BW-1:0]         rd_bank;
  logic [BW-1:0]         lay_a, lay_b;
  logic [WW-1:0]         win_b;
  logic                  out_free;

  assign neff        = mrbm_pkg::pages_eff(pages_i);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign pop_o       = (state_q == S_IDLE);
  assign busy_o      = (state_q != S_IDLE);
  assign rd_bank     = bank_q[cmd_q.win];
  assign lay_a       = pages_i - 9'd2;
  assign lay_b       = pages_i - 9'd1;
  assign win_b       = {cmd_q.wr_win[WW-1:1], 1'b1};

  // three restoring steps per cycle, quotient bits 8 down to 0
  always_comb begin
    logic [16:0] rem;
    logic [16:0] dvs;
    int          k;
    rem = {8'b0, rem_q};
    for (int j = 0; j < 3; j++) begin
      k   = 8 - 3 * int'(cnt_q) - j;
      dvs = {8'b0, neff} << k;
      if (rem >= dvs) begin
        rem = rem - dvs;
      end
    end
    rem_d = rem[BW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    rsp_d       = rsp_q;
    for (int w = 0; w < mrbm_pkg::WINDOWS; w++) begin
      bank_d[w] = bank_q[w];
    end
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        if (rd_i.valid) begin
          cmd_d   = cmd_i;
          state_d = (cmd_i.op == mrbm_pkg::OP_WRITE && cmd_i.do_mod && neff != '0)
                    ? S_DIV : S_EXEC;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd2) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          rsp_d       = '0;
          state_d     = S_IDLE;
          case (cmd_q.op)
            mrbm_pkg::OP_READ: begin
              if (rd_bank < neff) begin
                rsp_d.rom_hit    = 1'b1;
                rsp_d.rom_offset = {rd_bank[7:0], cmd_q.ofs};
              end
            end
            mrbm_pkg::OP_WRITE: begin
              if (cmd_q.wr_en) begin
                bank_d[cmd_q.wr_win] = rem_q;
                if (cmd_q.pair) begin
                  bank_d[win_b] = rem_q + 9'd1;
                  rsp_d.register_written = (bank_q[cmd_q.wr_win] != rem_q)
                                           || (bank_q[win_b] != rem_q + 9'd1);
                end else begin
                  rsp_d.register_written = (bank_q[cmd_q.wr_win] != rem_q);
                end
              end
            end
            mrbm_pkg::OP_LOAD: begin
              for (int w = 0; w < mrbm_pkg::WINDOWS; w++) begin
                bank_d[w] = mrbm_pkg::BANK_NONE;
              end
              if (front_i) begin
                bank_d[2] = 9'd0;
                bank_d[3] = 9'd1;
                bank_d[4] = 9'd2;
                bank_d[5] = 9'd3;
              end else begin
                bank_d[2] = lay_a;
                bank_d[3] = lay_b;
                bank_d[4] = lay_a;
                bank_d[5] = lay_b;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int w = 0; w < mrbm_pkg::WINDOWS; w++) begin
        bank_q[w] <= mrbm_pkg::BANK_NONE;
      end
      bank_q[2] <= mrbm_pkg::PAGES_RESET - 9'd2;
      bank_q[3] <= mrbm_pkg::PAGES_RESET - 9'd1;
      bank_q[4] <= mrbm_pkg::PAGES_RESET - 9'd2;
      bank_q[5] <= mrbm_pkg::PAGES_RESET - 9'd1;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      for (int w = 0; w < mrbm_pkg::WINDOWS; w++) begin
        bank_q[w] <= bank_d[w];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    rsp_q <= rsp_d;
    if (state_q == S_IDLE) begin
      rem_q <= cmd_i.val;
    end else if (state_q == S_DIV) begin
      rem_q <= rem_d;
    end
  end

endmodule

// ===== src/megarom_bank_mapper.sv =====
// top level of the cartridge bank mapper
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------
//  in      | into      | in_valid_i/stall_o | in_req_i: opcode, address, data
//  out     | out of    | out_valid_o/stall_i| out_rsp_o: rom_hit, rom_offset, written
//  cfg     | into      | cfg_valid_i/ready_o| cfg_index_i, cfg_data_i
//
// reads, layout loads and plain-mode writes go from idle straight to the execute state in the back end,
// writes that reduce modulo a nonzero page count pass through the restoring divider state first
// reset loads the back-end start layout for 8 pages, all other windows unmapped
// the queue takes requests while the back end works; full queue raises in_stall_o
// a held response in the output register blocks only the back end
module megarom_bank_mapper #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mrbm_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mrbm_pkg::rsp_t out_rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [8:0]     cfg_data_i
);

  mrbm_pkg::mode_e mode_q;
  logic [8:0]      pages_q;
  logic            front_q;
  logic            q_full;
  logic            q_push;
  logic            q_pop;
  mrbm_pkg::cmd_t  cmd_in;
  mrbm_pkg::cmd_t  cmd_out;
  mrbm_pkg::qrd_t  q_rd;
  logic            back_busy;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= mrbm_pkg::MODE_PLAIN;
      pages_q <= mrbm_pkg::PAGES_RESET;
      front_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        mrbm_pkg::CFG_MODE:  mode_q  <= mrbm_pkg::mode_e'(cfg_data_i[1:0]);
        mrbm_pkg::CFG_PAGES: pages_q <= cfg_data_i;
        mrbm_pkg::CFG_FRONT: front_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  mrbm_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .mode_i     (mode_q),
    .pages_i    (pages_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .cmd_o      (cmd_in)
  );

  mrbm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (cmd_in),
    .full_o (q_full),
    .rd_o   (q_rd),
    .pop_i  (q_pop),
    .cmd_o  (cmd_out)
  );

  mrbm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_i        (q_rd),
    .pop_o       (q_pop),
    .cmd_i       (cmd_out),
    .pages_i     (pages_q),
    .front_i     (front_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .busy_o      (back_busy)
  );

  a_hit_not_written : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_rsp_o.rom_hit && out_rsp_o.register_written))
    else $error("response both hit and wrote a register");

  a_miss_zero_offset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_rsp_o.rom_hit) |-> (out_rsp_o.rom_offset == '0))
    else $error("miss response carries a nonzero offset");

  a_pop_starts_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_rd.valid && q_rd.pop) |=> back_busy)
    else $error("back end popped a command but did not start it");

endmodule

// ===== tb/sv/tb_megarom_bank_mapper.sv =====
// self-checking testbench for the cartridge bank mapper with a predicting scoreboard
`timescale 1ns / 1ps

module tb_megarom_bank_mapper;

  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned PHASE_ITEMS   = 60;
  localparam int unsigned IDLE_PERCENT  = 21;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct {
    mrbm_pkg::mode_e mode;
    logic [8:0]      pages;
    logic            front;
  } phase_cfg_t;

  class mapper_scoreboard;
    mrbm_pkg::mode_e           mode;
    int unsigned               pages;
    bit                        front;
    bit [mrbm_pkg::BANK_W-1:0] banks [mrbm_pkg::WINDOWS];
    mrbm_pkg::rsp_t            expected_q [$];
    int unsigned               errors;

    function new();
      mode   = mrbm_pkg::MODE_PLAIN;
      pages  = mrbm_pkg::PAGES_RESET;
      front  = 1'b0;
      errors = 0;
      load_start();
    endfunction

    function int unsigned eff_pages();
      return (pages > mrbm_pkg::MAX_PAGES) ? mrbm_pkg::MAX_PAGES : pages;
    endfunction

    function int unsigned wrap(int unsigned v);
      int unsigned n;
      n = eff_pages();
      return (n == 0) ? v : v % n;
    endfunction

    function bit put_bank(int unsigned w, int unsigned b);
      bit [mrbm_pkg::BANK_W-1:0] nb;
      nb = mrbm_pkg::BANK_W'(b);
      if (banks[w[mrbm_pkg::WIN_W-1:0]] == nb) return 1'b0;
      banks[w[mrbm_pkg::WIN_W-1:0]] = nb;
      return 1'b1;
    endfunction

    function void load_start();
      foreach (banks[i]) banks[i] = mrbm_pkg::BANK_NONE;
      if (front) begin
        for (int i = 0; i < 4; i++) banks[mrbm_pkg::WIN_FIRST + i] = mrbm_pkg::BANK_W'(i);
      end else begin
        banks[2] = mrbm_pkg::BANK_W'(pages - 2);
        banks[3] = mrbm_pkg::BANK_W'(pages - 1);
        banks[4] = mrbm_pkg::BANK_W'(pages - 2);
        banks[5] = mrbm_pkg::BANK_W'(pages - 1);
      end
    endfunction

    function bit decode_write(bit [15:0] addr, bit [7:0] data);
      int unsigned w;
      int unsigned b;
      int unsigned first;
      int unsigned v;
      bit          c1;
      bit          c2;
      w = addr[15:13];
      case (mode)
        mrbm_pkg::MODE_PLAIN: begin
          if (w >= mrbm_pkg::WIN_REG && w <= mrbm_pkg::WIN_LAST && addr[12:0] == 13'd0) begin
            b = data & mrbm_pkg::PLAIN_MASK;
            if (b >= eff_pages()) b = mrbm_pkg::BANK_NONE;
            return put_bank(w, b);
          end
        end
        mrbm_pkg::MODE_SCC: begin
          if (w >= mrbm_pkg::WIN_FIRST && w <= mrbm_pkg::WIN_LAST
              && addr[12:0] == mrbm_pkg::SCC_OFS)
            return put_bank(w, wrap(data));
        end
        mrbm_pkg::MODE_8K: begin
          if (w == mrbm_pkg::WIN_REG)
            return put_bank(addr[12:11] + mrbm_pkg::WIN_FIRST, wrap(data));
        end
        default: begin
          if (w == mrbm_pkg::WIN_REG && !addr[11]) begin
            first = addr[12] ? mrbm_pkg::WIN_HIGH : mrbm_pkg::WIN_FIRST;
            v     = wrap(data * 2);
            c1    = put_bank(first, v);
            c2    = put_bank(first + 1, v + 1);
            return c1 | c2;
          end
        end
      endcase
      return 1'b0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [8:0] val);
      case (idx)
        mrbm_pkg::CFG_MODE:  mode  = mrbm_pkg::mode_e'(val[1:0]);
        mrbm_pkg::CFG_PAGES: pages = val;
        mrbm_pkg::CFG_FRONT: front = val[0];
        default: ;
      endcase
    endfunction

    function void note_request(mrbm_pkg::req_t r);
      mrbm_pkg::rsp_t            e;
      bit [mrbm_pkg::BANK_W-1:0] b;
      e = '0;
      case (mrbm_pkg::op_e'(r.opcode))
        mrbm_pkg::OP_READ: begin
          b = banks[r.address[15:13]];
          if (b < eff_pages()) begin
            e.rom_hit    = 1'b1;
            e.rom_offset = mrbm_pkg::ROM_W'({b, r.address[12:0]});
          end
        end
        mrbm_pkg::OP_WRITE: e.register_written = decode_write(r.address, r.data);
        mrbm_pkg::OP_LOAD:  load_start();
        default: ;
      endcase
      expected_q.push_back(e);
    endfunction

    function void check_response(mrbm_pkg::rsp_t got);
      mrbm_pkg::rsp_t e;
      if (expected_q.size() == 0) begin
        $error("response with no request outstanding");
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.rom_hit !== e.rom_hit) begin
        $error("rom_hit: expected %0d, got %0d", e.rom_hit, got.rom_hit);
        errors++;
      end
      if (got.rom_offset !== e.rom_offset) begin
        $error("rom_offset: expected 0x%06h, got 0x%06h", e.rom_offset, got.rom_offset);
        errors++;
      end
      if (got.register_written !== e.register_written) begin
        $error("register_written: expected %0d, got %0d", e.register_written,
               got.register_written);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_stall_o;
  mrbm_pkg::req_t in_req_i;
  logic           out_valid_o;
  logic           out_stall_i;
  mrbm_pkg::rsp_t out_rsp_o;
  logic           cfg_valid_i;
  logic           cfg_ready_o;
  logic [1:0]     cfg_index_i;
  logic [8:0]     cfg_data_i;

  mapper_scoreboard sb;
  bit               no_idle;
  bit               driving;
  int unsigned      cycle_cnt;

  phase_cfg_t phases [12] = '{
    '{mrbm_pkg::MODE_PLAIN, 9'd8,   1'b0},
    '{mrbm_pkg::MODE_SCC,   9'd256, 1'b1},
    '{mrbm_pkg::MODE_8K,    9'd13,  1'b0},
    '{mrbm_pkg::MODE_16K,   9'd256, 1'b0},
    '{mrbm_pkg::MODE_16K,   9'd9,   1'b1},
    '{mrbm_pkg::MODE_SCC,   9'd0,   1'b0},
    '{mrbm_pkg::MODE_PLAIN, 9'd300, 1'b1},
    '{mrbm_pkg::MODE_8K,    9'd1,   1'b0},
    '{mrbm_pkg::MODE_16K,   9'd511, 1'b1},
    '{mrbm_pkg::MODE_PLAIN, 9'd32,  1'b0},
    '{mrbm_pkg::MODE_8K,    9'd2,   1'b1},
    '{mrbm_pkg::MODE_SCC,   9'd100, 1'b0}
  };

  megarom_bank_mapper u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_response(out_rsp_o);
    out_stall_i <= no_idle ? 1'b0 : ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic mrbm_pkg::req_t random_req(mrbm_pkg::mode_e m);
    mrbm_pkg::req_t r;
    int unsigned    pick;
    logic [12:0]    ofs;
    pick      = $urandom_range(0, 99);
    ofs       = 13'($urandom);
    r.data    = 8'($urandom);
    r.address = 16'($urandom);
    r.opcode  = mrbm_pkg::OP_WRITE;
    if (pick < 38) begin
      r.opcode = mrbm_pkg::OP_READ;
      if (pick < 28) begin
        r.address = {3'($urandom_range(mrbm_pkg::WIN_FIRST, mrbm_pkg::WIN_LAST)), ofs};
      end
    end else if (pick < 78) begin
      // mapper register addresses of the active scheme
      case (m)
        mrbm_pkg::MODE_PLAIN:
          r.address = {3'($urandom_range(mrbm_pkg::WIN_REG, mrbm_pkg::WIN_LAST)), 13'd0};
        mrbm_pkg::MODE_SCC:
          r.address = {3'($urandom_range(mrbm_pkg::WIN_FIRST, mrbm_pkg::WIN_LAST)),
                       mrbm_pkg::SCC_OFS};
        mrbm_pkg::MODE_8K:
          r.address = {mrbm_pkg::WIN_REG, ofs};
        default:
          r.address = {mrbm_pkg::WIN_REG, ofs & ~13'h0800};
      endcase
    end else if (pick >= 94) begin
      r.opcode = mrbm_pkg::OP_NONE;
    end else if (pick >= 88) begin
      r.opcode = mrbm_pkg::OP_LOAD;
    end
    return r;
  endfunction

  task automatic send_req(mrbm_pkg::req_t r);
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    driving = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
    if (!no_idle && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      driving = 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    if (driving) begin
      in_valid_i <= 1'b0;
      driving = 1'b0;
    end
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(phase_cfg_t c);
    logic [1:0] idx [3];
    logic [8:0] val [3];
    idx = '{mrbm_pkg::CFG_MODE, mrbm_pkg::CFG_PAGES, mrbm_pkg::CFG_FRONT};
    val = '{{7'd0, c.mode}, c.pages, {8'd0, c.front}};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    sb = new();
    no_idle = 1'b0;
    driving = 1'b0;
    cycle_cnt <= 0;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_req_i <= '0;
    out_stall_i <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= mrbm_pkg::CFG_MODE;
    cfg_data_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset layout, plain scheme with eight pages
    send_req('{mrbm_pkg::OP_READ,  16'h0000, 8'h00});
    send_req('{mrbm_pkg::OP_READ,  16'hffff, 8'hff});
    send_req('{mrbm_pkg::OP_READ,  16'h4000, 8'h00});
    send_req('{mrbm_pkg::OP_READ,  16'h5fff, 8'h00});
    send_req('{mrbm_pkg::OP_READ,  16'hbfff, 8'h00});
    send_req('{mrbm_pkg::OP_WRITE, 16'h6000, 8'h05});
    send_req('{mrbm_pkg::OP_WRITE, 16'h6000, 8'h05});
    send_req('{mrbm_pkg::OP_WRITE, 16'h8000, 8'hff});
    send_req('{mrbm_pkg::OP_WRITE, 16'ha000, 8'h00});
    send_req('{mrbm_pkg::OP_WRITE, 16'h6001, 8'h03});
    send_req('{mrbm_pkg::OP_WRITE, 16'h4000, 8'h01});
    send_req('{mrbm_pkg::OP_READ,  16'h6123, 8'h00});
    send_req('{mrbm_pkg::OP_READ,  16'h8abc, 8'h00});
    send_req('{mrbm_pkg::OP_READ,  16'ha000, 8'h00});
    send_req('{mrbm_pkg::OP_NONE,  16'hffff, 8'hff});
    send_req('{mrbm_pkg::OP_LOAD,  16'h0000, 8'h00});
    send_req('{mrbm_pkg::OP_READ,  16'h8000, 8'h00});
    send_req('{mrbm_pkg::OP_WRITE, 16'he000, 8'hff});
    send_req('{mrbm_pkg::OP_READ,  16'h2000, 8'hff});

    foreach (phases[p]) begin
      drain();
      set_config(phases[p]);
      no_idle = (p == 3);
      send_req('{mrbm_pkg::OP_LOAD, 16'($urandom), 8'($urandom)});
      repeat (PHASE_ITEMS) send_req(random_req(sb.mode));
    end
    no_idle = 1'b0;
    drain();
    repeat (20) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
